// ===== rtl/crcf_pkg.sv =====
`default_nettype none
package crcf_pkg;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Result status codes.
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  // Command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] crc_value;
    logic        frame_end;
  } out_beat_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_ECHO,
    OP_APPEND,
    OP_CHECK
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic [1:0]  status;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_push_t;

  // One byte of the reflected CRC update, least significant bit first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crcf_front.sv =====
`default_nettype none
module crcf_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  crcf_pkg::in_beat_t   beat_i,
  output crcf_pkg::op_push_t   push_o
);
  import crcf_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  older_q, older_d;
  logic [7:0]  newer_q, newer_d;
  logic [1:0]  held_q, held_d;

  logic [15:0] crc_feed;
  logic [7:0]  feed_byte;
  logic        feed_en;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc;

  always_comb begin
    // Append feeds the new byte; check feeds the byte falling out of the hold pair.
    feed_byte = (beat_i.command == CMD_APPEND) ? beat_i.data_byte : older_q;
    feed_en   = (beat_i.command == CMD_APPEND) || (held_q == 2'd2);
    crc_feed  = crc_byte(crc_q, feed_byte);
    crc_upd   = feed_en ? crc_feed : crc_q;
    rx_crc    = {beat_i.data_byte, newer_q};

    crc_d   = crc_q;
    older_d = older_q;
    newer_d = newer_q;
    held_d  = held_q;

    push_o.valid     = 1'b0;
    push_o.op.kind   = OP_ECHO;
    push_o.op.data   = beat_i.data_byte;
    push_o.op.crc    = crc_upd;
    push_o.op.status = ST_DATA;

    if (accept_i) begin
      crc_d = crc_upd;
      if (beat_i.command == CMD_APPEND) begin
        push_o.valid   = 1'b1;
        push_o.op.kind = beat_i.last_byte ? OP_APPEND : OP_ECHO;
      end else begin
        older_d = newer_q;
        newer_d = beat_i.data_byte;
        held_d  = (held_q == 2'd2) ? 2'd2 : held_q + 2'd1;
        if (beat_i.last_byte) begin
          push_o.valid   = 1'b1;
          push_o.op.kind = OP_CHECK;
          if (held_q == 2'd0) begin
            push_o.op.status = ST_SHORT;
          end else if (rx_crc == crc_upd) begin
            push_o.op.status = ST_MATCH;
          end else begin
            push_o.op.status = ST_MISMATCH;
          end
        end
      end
      if (beat_i.last_byte) begin
        crc_d   = CRC_START;
        older_d = 8'h00;
        newer_d = 8'h00;
        held_d  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_START;
      older_q <= 8'h00;
      newer_q <= 8'h00;
      held_q  <= 2'd0;
    end else begin
      crc_q   <= crc_d;
      older_q <= older_d;
      newer_q <= newer_d;
      held_q  <= held_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crcf_queue.sv =====
`default_nettype none
module crcf_queue #(
  parameter int Depth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  crcf_pkg::op_push_t   push_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output crcf_pkg::op_t        head_o,
  output logic                 empty_o
);
  import crcf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  op_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrOne;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrOne;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntOne;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crcf_back.sv =====
`default_nettype none
module crcf_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  crcf_pkg::op_t        head_i,
  input  wire                  head_empty_i,
  output logic                 head_pop_o,
  output crcf_pkg::out_beat_t  result_o,
  output logic                 empty_o,
  input  wire                  pop_i
);
  import crcf_pkg::*;

  op_t        op_q;
  logic       valid_q, valid_d;
  logic [1:0] phase_q, phase_d;
  logic       last_phase;
  logic       load;

  assign empty_o    = !valid_q;
  assign last_phase = (op_q.kind != OP_APPEND) || (phase_q == 2'd2);
  assign load       = !head_empty_i && (!valid_q || (pop_i && last_phase));
  assign head_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = 2'd0;
    end else if (valid_q && pop_i) begin
      if (last_phase) begin
        valid_d = 1'b0;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end
  end

  always_comb begin
    result_o.out_byte  = op_q.data;
    result_o.status    = ST_DATA;
    result_o.crc_value = 16'h0000;
    result_o.frame_end = 1'b0;
    unique case (op_q.kind)
      OP_ECHO: begin
      end
      OP_APPEND: begin
        if (phase_q == 2'd1) begin
          result_o.out_byte = op_q.crc[7:0];
        end else if (phase_q == 2'd2) begin
          result_o.out_byte  = op_q.crc[15:8];
          result_o.crc_value = op_q.crc;
          result_o.frame_end = 1'b1;
        end
      end
      OP_CHECK: begin
        result_o.out_byte  = 8'h00;
        result_o.status    = op_q.status;
        result_o.crc_value = op_q.crc;
        result_o.frame_end = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 2'd0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= head_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/modbus_crc16_frame_engine_unit.sv =====
// Channel   Handshake            Payload                 Direction
// input     push / full          in_beat_i  (in_beat_t)  into the block
// result    empty / pop          result_o   (out_beat_t) out of the block
//
// The front end takes one byte per cycle while the queue has room and updates the CRC in that cycle.
// In append mode each byte gives one result beat, and the last byte adds two
// more beats carrying the CRC, low byte first; a check frame gives one beat.
// With both sides idle, an accepted byte's operation is written into the queue
// and then loaded into the back end before it reaches the result ports.
// Full rises while the queue holds QueueDepth operations; it then holds off
// every byte, check bytes that produce no beat included, until a slot frees.
// Reset clears the CRC to its start value, empties the hold pair and the queue.
// The operation queue between front and back lets either side stall alone.
`default_nettype none
module modbus_crc16_frame_engine_unit #(
  parameter int QueueDepth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  crcf_pkg::in_beat_t   in_beat_i,
  output logic                 empty,
  input  wire                  pop,
  output crcf_pkg::out_beat_t  result_o
);
  import crcf_pkg::*;

  op_push_t op_push;
  op_t      q_head;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     accept;

  // Bytes are taken whenever the operation queue has room; a byte that yields
  // no beat is simply not written into the queue.
  assign full   = q_full;
  assign accept = push && !q_full;

  crcf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .beat_i  (in_beat_i),
    .push_o  (op_push)
  );

  crcf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head),
    .empty_o(q_empty)
  );

  // The back end holds the current operation and steps through its beats.
  crcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .head_empty_i(q_empty),
    .head_pop_o  (q_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
`default_nettype wire

// ===== rtl/crcf_checker.sv =====
`default_nettype none
module crcf_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  empty,
  input wire                  pop,
  input crcf_pkg::out_beat_t  result_i
);
  import crcf_pkg::*;

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty during reset");

  a_check_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_i.status != ST_DATA) |->
      (result_i.frame_end && result_i.out_byte == 8'h00))
    else $error("check result not marked as frame end");

  a_crc_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_i.frame_end) |-> (result_i.crc_value == 16'h0000))
    else $error("CRC value shown on a non-final beat");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_i)))
    else $error("stalled result beat changed");

endmodule

bind modbus_crc16_frame_engine_unit crcf_checker u_crcf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .result_i(result_o)
);
`default_nettype wire
